/* hdl/kpc_pkg.sv */
// Shared types, codes and constants of the key press classifier.
`default_nettype none

package kpc_pkg;

  // Number of keys tracked; the key index field is fixed at two bits.
  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned KEY_W     = 2;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_WAIT     = 3'd4
  } kpc_state_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4,
    EV_SHORT   = 3'd5,
    EV_DOUBLE  = 3'd6
  } kpc_event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_SHORT     = 3'd1,
    CFG_LONG      = 3'd2,
    CFG_REPEAT    = 3'd3,
    CFG_DOUBLE    = 3'd4,
    CFG_PRESS_LVL = 3'd5
  } kpc_cfg_idx_e;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] short_press_ms;
    logic [MS_W-1:0] long_press_ms;
    logic [MS_W-1:0] repeat_ms;
    logic [MS_W-1:0] double_click_ms;
    logic            pressed_level;
  } kpc_cfg_t;

  // One key's record as held in the state memory.
  typedef struct packed {
    kpc_state_e         state;
    logic               prev_level;
    logic [STAMP_W-1:0] press_stamp;
    logic [STAMP_W-1:0] release_stamp;
    logic [STAMP_W-1:0] event_stamp;
    logic               long_reported;
  } kpc_entry_t;

  localparam kpc_entry_t ENTRY_RESET = '{
    state:         ST_IDLE,
    prev_level:    1'b1,
    press_stamp:   '0,
    release_stamp: '0,
    event_stamp:   '0,
    long_reported: 1'b0
  };

  localparam kpc_cfg_t CFG_RESET = '{
    debounce_ms:     16'd20,
    short_press_ms:  16'd50,
    long_press_ms:   16'd1000,
    repeat_ms:       16'd200,
    double_click_ms: 16'd300,
    pressed_level:   1'b0
  };

endpackage

`default_nettype wire

/* hdl/key_press_classifier_unit.sv */
// Top level of the key press classifier: stream ports, config and pipeline.
`default_nettype none

// Key press classifier. Each input beat is one scan sample of one key
// (index, pin level, millisecond timestamp); each sample yields exactly one
// output beat carrying the key index, an event code (none, press, release,
// long, repeat, short, double) and the pressed flag.
// Per-key state lives in a small synchronous memory. The accepting edge
// issues the read; when the update stage advances, the record is updated
// and written back while the result is loaded into the output register. A
// key on the very next beat is served from the forwarded write data.
// The sample is registered in the update stage and its result in the
// output register before the output handshake. The block sustains one
// beat per cycle while the receiver accepts, set by the single
// read-modify-write pass through the state memory.
// Reset returns every key to idle with the released level as its previous
// level, zero timestamps, and loads the default thresholds. When the
// receiver stalls, the output register holds its beat, the update stage
// holds one more sample, and then tready drops until the output drains.
// Thresholds are to be written through the plain write port while idle; the block does not enforce it.

module key_press_classifier_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [kpc_pkg::MS_W-1:0]           cfg_data_i,
  // Scan samples.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: [1:0] key_index, [2] pin_level, [34:3] now_ms, [39:35] zero.
  input  wire logic [kpc_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // Classified events.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: [1:0] key_out, [4:2] event_code, [5] is_pressed, [7:6] zero.
  output logic [kpc_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o
);

  kpc_pkg::kpc_cfg_t cfg_q;

  logic                              s1_valid_q;
  logic [kpc_pkg::KEY_W-1:0]         s1_key_q;
  logic                              s1_lvl_q;
  logic [kpc_pkg::STAMP_W-1:0]       s1_now_q;

  logic                              out_valid_q;
  logic [kpc_pkg::OUT_DATA_W-1:0]    out_data_q;
  logic [kpc_pkg::OUT_DATA_W-1:0]    out_data_d;

  logic                              in_fire;
  logic                              s1_adv;
  logic                              s1_in_range;
  logic                              wr_en;

  kpc_pkg::kpc_entry_t               cur_entry;
  kpc_pkg::kpc_entry_t               nxt_entry;
  kpc_pkg::kpc_event_e               step_ev;
  kpc_pkg::kpc_event_e               ev_out;
  logic                              down;

  // Configuration registers; writes to unlisted indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= kpc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (kpc_pkg::kpc_cfg_idx_e'(cfg_index_i))
        kpc_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms     <= cfg_data_i;
        kpc_pkg::CFG_SHORT:     cfg_q.short_press_ms  <= cfg_data_i;
        kpc_pkg::CFG_LONG:      cfg_q.long_press_ms   <= cfg_data_i;
        kpc_pkg::CFG_REPEAT:    cfg_q.repeat_ms       <= cfg_data_i;
        kpc_pkg::CFG_DOUBLE:    cfg_q.double_click_ms <= cfg_data_i;
        kpc_pkg::CFG_PRESS_LVL: cfg_q.pressed_level   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The update stage moves on when the output register is free or draining.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign s1_in_range = ({1'b0, s1_key_q} < kpc_pkg::NUM_KEYS[kpc_pkg::KEY_W:0]);
  assign wr_en       = s1_adv && s1_in_range;

  kpc_state_mem u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_key_i  (s_axis_tdata_i[kpc_pkg::KEY_W-1:0]),
    .wr_en_i   (wr_en),
    .wr_key_i  (s1_key_q),
    .wr_data_i (nxt_entry),
    .rd_data_o (cur_entry)
  );

  kpc_step u_step (
    .cfg_i  (cfg_q),
    .cur_i  (cur_entry),
    .lvl_i  (s1_lvl_q),
    .now_i  (s1_now_q),
    .nxt_o  (nxt_entry),
    .ev_o   (step_ev),
    .down_o (down)
  );

  assign ev_out     = s1_in_range ? step_ev : kpc_pkg::EV_NONE;
  assign out_data_d = {2'b00, down, ev_out, s1_key_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q <= s_axis_tdata_i[kpc_pkg::KEY_W-1:0];
      s1_lvl_q <= s_axis_tdata_i[kpc_pkg::KEY_W];
      s1_now_q <= s_axis_tdata_i[kpc_pkg::KEY_W+kpc_pkg::STAMP_W:kpc_pkg::KEY_W+1];
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* hdl/kpc_state_mem.sv */
// Per-key state memory with valid bits and write-to-read forwarding.
`default_nettype none

module kpc_state_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [kpc_pkg::KEY_W-1:0]  rd_key_i,
  input  wire logic                       wr_en_i,
  input  wire logic [kpc_pkg::KEY_W-1:0]  wr_key_i,
  input  wire kpc_pkg::kpc_entry_t        wr_data_i,
  output kpc_pkg::kpc_entry_t             rd_data_o
);

  kpc_pkg::kpc_entry_t mem_q [kpc_pkg::NUM_KEYS];
  kpc_pkg::kpc_entry_t rd_data_q;
  kpc_pkg::kpc_entry_t fwd_data_q;
  logic [kpc_pkg::NUM_KEYS-1:0] valid_q;
  logic rd_vld_q;
  logic fwd_hit_q;
  logic fwd_hit_d;

  // A read issued in the same cycle as a write to the same key would see
  // stale data, so the written record is captured and used instead.
  assign fwd_hit_d = wr_en_i && (wr_key_i == rd_key_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_key_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_key_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_key_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= valid_q[rd_key_i];
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_data_q;
    end else begin
      rd_data_o = kpc_pkg::ENTRY_RESET;
    end
  end

endmodule

`default_nettype wire

/* hdl/kpc_step.sv */
// Next-state and event logic for one key sample.
`default_nettype none

module kpc_step (
  input  wire kpc_pkg::kpc_cfg_t                 cfg_i,
  input  wire kpc_pkg::kpc_entry_t               cur_i,
  input  wire logic                              lvl_i,
  input  wire logic [kpc_pkg::STAMP_W-1:0]       now_i,
  output kpc_pkg::kpc_entry_t                    nxt_o,
  output kpc_pkg::kpc_event_e                    ev_o,
  output logic                                   down_o
);

  logic rise;
  logic [kpc_pkg::STAMP_W-1:0] since_press;
  logic [kpc_pkg::STAMP_W-1:0] since_release;
  logic [kpc_pkg::STAMP_W-1:0] since_event;
  logic [kpc_pkg::STAMP_W-1:0] deb_lim;
  logic [kpc_pkg::STAMP_W-1:0] short_lim;
  logic [kpc_pkg::STAMP_W-1:0] long_lim;
  logic [kpc_pkg::STAMP_W-1:0] rep_lim;
  logic [kpc_pkg::STAMP_W-1:0] dbl_lim;

  assign down_o = (lvl_i == cfg_i.pressed_level);
  assign rise   = down_o && (cur_i.prev_level != cfg_i.pressed_level);

  // Differences wrap modulo 2^32 so the timestamp may roll over.
  assign since_press   = now_i - cur_i.press_stamp;
  assign since_release = now_i - cur_i.release_stamp;
  assign since_event   = now_i - cur_i.event_stamp;

  assign deb_lim   = {16'd0, cfg_i.debounce_ms};
  assign short_lim = {16'd0, cfg_i.short_press_ms};
  assign long_lim  = {16'd0, cfg_i.long_press_ms};
  assign rep_lim   = {16'd0, cfg_i.repeat_ms};
  assign dbl_lim   = {16'd0, cfg_i.double_click_ms};

  always_comb begin
    nxt_o = cur_i;
    ev_o  = kpc_pkg::EV_NONE;
    case (cur_i.state)
      kpc_pkg::ST_IDLE: begin
        if (rise) begin
          nxt_o.state       = kpc_pkg::ST_DEBOUNCE;
          nxt_o.press_stamp = now_i;
        end
      end
      kpc_pkg::ST_DEBOUNCE: begin
        if (down_o) begin
          if (since_press >= deb_lim) begin
            nxt_o.state         = kpc_pkg::ST_PRESSED;
            nxt_o.long_reported = 1'b0;
            ev_o                = kpc_pkg::EV_PRESS;
          end
        end else begin
          nxt_o.state = kpc_pkg::ST_IDLE;
        end
      end
      kpc_pkg::ST_PRESSED: begin
        if (!down_o) begin
          nxt_o.release_stamp = now_i;
          ev_o                = kpc_pkg::EV_RELEASE;
          if ((since_press >= short_lim) && (since_press < long_lim)) begin
            nxt_o.event_stamp = now_i;
            nxt_o.state       = kpc_pkg::ST_WAIT;
          end else begin
            nxt_o.state = kpc_pkg::ST_IDLE;
          end
        end else if (!cur_i.long_reported && (since_press >= long_lim)) begin
          nxt_o.long_reported = 1'b1;
          nxt_o.state         = kpc_pkg::ST_LONG;
          nxt_o.event_stamp   = now_i;
          ev_o                = kpc_pkg::EV_LONG;
        end
      end
      kpc_pkg::ST_LONG: begin
        if (!down_o) begin
          nxt_o.state = kpc_pkg::ST_IDLE;
          ev_o        = kpc_pkg::EV_RELEASE;
        end else if (since_event >= rep_lim) begin
          nxt_o.event_stamp = now_i;
          ev_o              = kpc_pkg::EV_REPEAT;
        end
      end
      kpc_pkg::ST_WAIT: begin
        if (rise) begin
          ev_o              = (since_release <= dbl_lim) ? kpc_pkg::EV_DOUBLE
                                                         : kpc_pkg::EV_SHORT;
          nxt_o.state       = kpc_pkg::ST_DEBOUNCE;
          nxt_o.press_stamp = now_i;
        end else if (since_release > dbl_lim) begin
          ev_o        = kpc_pkg::EV_SHORT;
          nxt_o.state = kpc_pkg::ST_IDLE;
        end
      end
      default: begin
        nxt_o.state = kpc_pkg::ST_IDLE;
      end
    endcase
    nxt_o.prev_level = lvl_i;
  end

endmodule

`default_nettype wire
